FILE: rtl/core/iecu_pkg.sv
// Package: shared types and constants of the ICMP echo reply checker.
package iecu_pkg;

  // Folded checksum value of a packet that passes.
  localparam logic [15:0] SumAllOnes = 16'hffff;

  // Depth of the queue between front and back, and its pointer width.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_VALID     = 2'd0,
    STATUS_BAD_SUM   = 2'd1,
    STATUS_ID_DIFF   = 2'd2,
    STATUS_MALFORMED = 2'd3
  } status_e;

  // One classified byte, handed from the front to the back.
  typedef struct packed {
    logic [7:0]  data;        // packet byte
    logic        last;        // final byte of the packet
    logic        icmp;        // byte lies in the ICMP part
    logic        odd;         // odd offset within the ICMP part
    logic        id_hi;       // ICMP byte 4
    logic        id_lo;       // ICMP byte 5
    logic        malformed;   // length check failed (valid with last)
    logic [15:0] icmp_len;    // ICMP byte count (valid with last)
  } entry_t;

endpackage

FILE: rtl/core/iecu_byte_if.sv
// Interface: packet byte channel with valid/ready handshake.
interface iecu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/core/iecu_result_if.sv
// Interface: check result channel with valid/ready handshake.
interface iecu_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] icmp_length;
  logic [15:0] reply_id;

  modport source (output valid, output status, output icmp_length, output reply_id,
                  input ready);
  modport sink   (input valid, input status, input icmp_length, input reply_id,
                  output ready);
endinterface

FILE: rtl/core/iecu_cfg_if.sv
// Interface: configuration write channel for the expected identifier.
interface iecu_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] expected_id;

  modport source (output valid, output expected_id, input ready);
  modport sink   (input valid, input expected_id, output ready);
endinterface

FILE: rtl/core/iecu_front.sv
// Front: track byte position and lengths, classify each byte for the back.
module iecu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  iecu_byte_if.sink        pkt_in,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output iecu_pkg::entry_t push_data_o
);
  import iecu_pkg::*;

  logic [15:0] pos_q, pos_d;
  logic [5:0]  hb_q, hb_d;
  logic [15:0] dl_q, dl_d;
  logic        accept;
  logic [15:0] hb_ext;
  logic [15:0] off;
  logic [16:0] count;
  logic        in_icmp;

  assign pkt_in.ready = push_ready_i;
  assign push_valid_o = pkt_in.valid;
  assign accept       = pkt_in.valid & push_ready_i;

  // Capture header length and total length as their bytes pass.
  always_comb begin
    hb_d = hb_q;
    dl_d = dl_q;
    if (pos_q == 16'd0) begin
      hb_d = {pkt_in.data_byte[3:0], 2'b00};
    end else if (pos_q == 16'd2) begin
      dl_d = {pkt_in.data_byte, dl_q[7:0]};
    end else if (pos_q == 16'd3) begin
      dl_d = {dl_q[15:8], pkt_in.data_byte};
    end
  end

  // Classify the byte against the ICMP window.
  assign hb_ext  = {10'd0, hb_d};
  assign off     = pos_q - hb_ext;
  assign count   = {1'b0, pos_q} + 17'd1;
  assign in_icmp = (pos_q >= 16'd4) && (hb_d != 6'd0) && (pos_q >= hb_ext) &&
                   (pos_q < dl_d);

  always_comb begin
    push_data_o.data      = pkt_in.data_byte;
    push_data_o.last      = pkt_in.last_byte;
    push_data_o.icmp      = in_icmp;
    push_data_o.odd       = off[0];
    push_data_o.id_hi     = in_icmp && (off == 16'd4);
    push_data_o.id_lo     = in_icmp && (off == 16'd5);
    push_data_o.malformed = (count < 17'd4) || (hb_d == 6'd0) || (dl_d < hb_ext) ||
                            (count < {1'b0, dl_d});
    push_data_o.icmp_len  = (dl_d >= hb_ext) ? (dl_d - hb_ext) : 16'd0;
  end

  // Advance position (saturating), clear after the last byte.
  always_comb begin
    pos_d = pos_q;
    if (pkt_in.last_byte) begin
      pos_d = '0;
    end else if (pos_q != 16'hffff) begin
      pos_d = pos_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      hb_q  <= '0;
      dl_q  <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
      hb_q  <= pkt_in.last_byte ? 6'd0 : hb_d;
      dl_q  <= pkt_in.last_byte ? 16'd0 : dl_d;
    end
  end

endmodule

FILE: rtl/core/iecu_queue.sv
// Queue: short FIFO of classified bytes between front and back.
module iecu_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  iecu_pkg::entry_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output iecu_pkg::entry_t pop_data_o
);
  import iecu_pkg::*;

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Store the request at the write pointer.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/iecu_back.sv
// Back: accumulate the checksum, capture the identifier, register the result.
module iecu_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  iecu_pkg::entry_t pop_data_i,
  input  logic [15:0]      expected_id_i,
  iecu_result_if.source    res_out
);
  import iecu_pkg::*;

  logic [15:0] sum_q, sum_n;
  logic [7:0]  hold_q, hold_n;
  logic [15:0] id_q, id_n;
  logic        res_valid_q;
  status_e     status_q, status_n;
  logic [15:0] len_q;
  logic [15:0] rid_q;
  logic        out_free;
  logic        pop;
  logic        add_word, add_pad;
  logic [15:0] word;
  logic [16:0] raw_sum;

  assign out_free    = !res_valid_q || res_out.ready;
  assign pop_ready_o = !pop_data_i.last || out_free;
  assign pop         = pop_valid_i & pop_ready_o;

  // Hold the high byte and capture identifier bytes.
  always_comb begin
    hold_n = hold_q;
    id_n   = id_q;
    if (pop_data_i.icmp && !pop_data_i.odd) begin
      hold_n = pop_data_i.data;
    end
    if (pop_data_i.id_hi) begin
      id_n = {pop_data_i.data, id_q[7:0]};
    end else if (pop_data_i.id_lo) begin
      id_n = {id_q[15:8], pop_data_i.data};
    end
  end

  // Add a full word or the zero-padded trailing byte, end-around carry.
  assign add_word = pop_data_i.icmp && pop_data_i.odd;
  assign add_pad  = pop_data_i.last && !pop_data_i.malformed && pop_data_i.icmp_len[0];
  assign word     = add_word ? {hold_q, pop_data_i.data} : {hold_n, 8'h00};
  assign raw_sum  = {1'b0, sum_q} + {1'b0, word};

  always_comb begin
    sum_n = sum_q;
    if (add_word || add_pad) begin
      sum_n = raw_sum[15:0] + {15'd0, raw_sum[16]};
    end
  end

  // Decide status: length first, then checksum, then identifier.
  always_comb begin
    priority if (pop_data_i.malformed) begin
      status_n = STATUS_MALFORMED;
    end else if (sum_n != SumAllOnes) begin
      status_n = STATUS_BAD_SUM;
    end else if (id_n != expected_id_i) begin
      status_n = STATUS_ID_DIFF;
    end else begin
      status_n = STATUS_VALID;
    end
  end

  // Update per-packet state, drop it after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      hold_q <= '0;
      id_q   <= '0;
    end else if (pop) begin
      if (pop_data_i.last) begin
        sum_q  <= '0;
        hold_q <= '0;
        id_q   <= '0;
      end else begin
        sum_q  <= sum_n;
        hold_q <= hold_n;
        id_q   <= id_n;
      end
    end
  end

  // Output register: load on the last byte, hold until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (pop && pop_data_i.last) begin
      res_valid_q <= 1'b1;
    end else if (res_out.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && pop_data_i.last) begin
      status_q <= status_n;
      len_q    <= pop_data_i.icmp_len;
      rid_q    <= id_n;
    end
  end

  assign res_out.valid       = res_valid_q;
  assign res_out.status      = status_q;
  assign res_out.icmp_length = len_q;
  assign res_out.reply_id    = rid_q;

endmodule

FILE: rtl/core/icmp_echo_reply_checker_unit.sv
// Top level: ICMP echo reply checker with front, queue and back.
//
// Takes a received IPv4 packet one byte per clock on pkt_in, while the queue
// has room, and returns one result per packet on res_out after the byte marked
// last: status (valid, bad checksum, identifier mismatch, malformed length), the
// ICMP byte count and the identifier found at ICMP bytes 4-5. A byte is accepted
// every cycle unless the queue is full; the back's single 16-bit
// end-around-carry adder takes at most one word per clock, so it keeps up with
// one byte per clock. The last byte passes through the queue, and the back then
// loads its output register. A stalled output holds only the last byte of the
// next packet; earlier bytes keep flowing into the back through a two-entry
// queue, and the input stalls once that queue is full. The user must write the
// expected identifier on cfg only while idle; the block does not enforce this.
module icmp_echo_reply_checker_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  iecu_byte_if.sink     pkt_in,
  iecu_result_if.source res_out,
  iecu_cfg_if.sink      cfg
);
  import iecu_pkg::*;

  logic        push_valid, push_ready;
  entry_t      push_data;
  logic        pop_valid, pop_ready;
  entry_t      pop_data;
  logic [15:0] expected_id_q;

  // Take configuration writes at any time.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= '0;
    end else if (cfg.valid) begin
      expected_id_q <= cfg.expected_id;
    end
  end

  iecu_front u_front (
    .clk_i,
    .rst_ni,
    .pkt_in,
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  iecu_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  iecu_back u_back (
    .clk_i,
    .rst_ni,
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_data_i    (pop_data),
    .expected_id_i (expected_id_q),
    .res_out
  );

endmodule

FILE: sim/icmp_echo_reply_checker_unit_tb.sv
// Testbench: ICMP echo reply checker, packet byte stimulus scored against a byte-level predictor.
module icmp_echo_reply_checker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iecu_pkg::*;

  localparam int unsigned ResetCycles    = 11;
  localparam int unsigned DrainCycles    = 16;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned MaxReported    = 10;

  // One expected check result per packet.
  typedef struct packed {
    status_e     status;
    logic [15:0] icmp_length;
    logic [15:0] reply_id;
  } reply_check_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  iecu_byte_if   pkt_in ();
  iecu_result_if res_out ();
  iecu_cfg_if    cfg ();

  icmp_echo_reply_checker_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pkt_in (pkt_in),
    .res_out(res_out),
    .cfg    (cfg)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor copy of the per-packet state and the identifier register.
  logic [15:0] rx_pos          = '0;
  logic [5:0]  rx_hdr_len      = '0;
  logic [15:0] rx_total_len    = '0;
  logic [15:0] rx_sum          = '0;
  logic [7:0]  rx_hi_byte      = '0;
  logic [15:0] rx_id           = '0;
  logic [15:0] cfg_expected_id = '0;

  reply_check_t reply_q[$];
  logic [7:0]   pkt_buf[$];

  int unsigned error_count = 0;
  int unsigned pkt_count   = 0;
  int unsigned byte_count  = 0;
  int unsigned status_count[4] = '{0, 0, 0, 0};

  bit idle_en         = 1'b0;
  bit long_hold_req   = 1'b0;
  bit long_hold_taken = 1'b0;

  // One's-complement add with end-around carry.
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Advance the predictor by one accepted byte; returns 1 when a result is due.
  function automatic bit predict_byte(input logic [7:0] b, input logic last,
                                      output reply_check_t r);
    logic [15:0] p;
    logic [15:0] off;
    logic [16:0] seen;
    logic        bad_len;
    p = rx_pos;
    r = '0;
    // Pick up header length and total length from the fixed header bytes.
    if (p == 16'd0) begin
      rx_hdr_len = {b[3:0], 2'b00};
    end else if (p == 16'd2) begin
      rx_total_len[15:8] = b;
    end else if (p == 16'd3) begin
      rx_total_len[7:0] = b;
    end
    // Sum the ICMP part and capture the identifier.
    if (p >= 16'd4 && rx_hdr_len != 6'd0 && p >= {10'd0, rx_hdr_len} && p < rx_total_len) begin
      off = p - {10'd0, rx_hdr_len};
      if (off == 16'd4) begin
        rx_id[15:8] = b;
      end else if (off == 16'd5) begin
        rx_id[7:0] = b;
      end
      if (!off[0]) begin
        rx_hi_byte = b;
      end else begin
        rx_sum = ones_add(rx_sum, {rx_hi_byte, b});
      end
    end
    if (!last) begin
      if (rx_pos != 16'hffff) rx_pos = rx_pos + 16'd1;
      return 1'b0;
    end
    // Close the packet: length checks, odd pad, checksum, then identifier.
    seen    = {1'b0, p} + 17'd1;
    bad_len = (seen < 17'd4) || (rx_hdr_len == 6'd0) ||
              (rx_total_len < {10'd0, rx_hdr_len}) || (seen < {1'b0, rx_total_len});
    r.icmp_length = (rx_total_len >= {10'd0, rx_hdr_len}) ?
                    rx_total_len - {10'd0, rx_hdr_len} : 16'd0;
    if (bad_len) begin
      r.status = STATUS_MALFORMED;
    end else begin
      if (r.icmp_length[0]) rx_sum = ones_add(rx_sum, {rx_hi_byte, 8'h00});
      if (rx_sum != SumAllOnes) begin
        r.status = STATUS_BAD_SUM;
      end else if (rx_id != cfg_expected_id) begin
        r.status = STATUS_ID_DIFF;
      end else begin
        r.status = STATUS_VALID;
      end
    end
    r.reply_id   = rx_id;
    rx_pos       = '0;
    rx_hdr_len   = '0;
    rx_total_len = '0;
    rx_sum       = '0;
    rx_hi_byte   = '0;
    rx_id        = '0;
    return 1'b1;
  endfunction

  // Offer one byte, wait for the request to be taken, then predict.
  task automatic send_byte(input logic [7:0] b, input logic last);
    reply_check_t r;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      pkt_in.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
    pkt_in.valid     <= 1'b1;
    pkt_in.data_byte <= b;
    pkt_in.last_byte <= last;
    do @(posedge clk_i); while (pkt_in.ready !== 1'b1);
    if (predict_byte(b, last, r)) begin
      reply_q.push_back(r);
      pkt_count++;
      status_count[int'(r.status)]++;
    end
    byte_count++;
  endtask

  task automatic send_packet();
    foreach (pkt_buf[i]) send_byte(pkt_buf[i], i == pkt_buf.size() - 1);
  endtask

  // Build a well-formed echo reply into pkt_buf, with a correct checksum when the ICMP part has 4 or more bytes.
  task automatic build_reply(input logic [3:0] ihl, input logic [15:0] len,
                             input logic [15:0] id);
    int unsigned hdr;
    logic [15:0] total;
    logic [15:0] sum;
    hdr   = ihl * 4;
    total = 16'(hdr + len);
    pkt_buf.delete();
    repeat (hdr + len) pkt_buf.push_back(8'($urandom_range(0, 255)));
    pkt_buf[0] = {4'h4, ihl};
    pkt_buf[2] = total[15:8];
    pkt_buf[3] = total[7:0];
    if (len > 0) pkt_buf[hdr] = 8'h00;
    if (len > 1) pkt_buf[hdr + 1] = 8'h00;
    if (len > 4) pkt_buf[hdr + 4] = id[15:8];
    if (len > 5) pkt_buf[hdr + 5] = id[7:0];
    if (len >= 4) begin
      pkt_buf[hdr + 2] = 8'h00;
      pkt_buf[hdr + 3] = 8'h00;
      sum = '0;
      for (int i = 0; i < len; i += 2) begin
        sum = ones_add(sum, {pkt_buf[hdr + i], (i + 1 < len) ? pkt_buf[hdr + i + 1] : 8'h00});
      end
      pkt_buf[hdr + 2] = ~sum[15:8];
      pkt_buf[hdr + 3] = ~sum[7:0];
    end
  endtask

  // Drop valid and wait until every pending result has come back.
  task automatic wait_for_replies();
    pkt_in.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_expected_id(input logic [15:0] id);
    wait_for_replies();
    cfg.valid       <= 1'b1;
    cfg.expected_id <= id;
    do @(posedge clk_i); while (cfg.ready !== 1'b1);
    cfg.valid       <= 1'b0;
    cfg_expected_id = id;
  endtask

  task automatic test_valid_replies();
    idle_en = 1'b1;
    build_reply(4'd5, 16'd8, cfg_expected_id);
    send_packet();
    // smallest header with an odd ICMP length
    build_reply(4'd1, 16'd7, cfg_expected_id);
    send_packet();
    build_reply(4'd15, 16'd6, cfg_expected_id);
    send_packet();
  endtask

  task automatic test_bad_checksum();
    build_reply(4'd5, 16'd8, cfg_expected_id);
    pkt_buf[26] = pkt_buf[26] ^ 8'h01;
    send_packet();
    // corrupt the odd trailing byte
    build_reply(4'd1, 16'd9, cfg_expected_id);
    pkt_buf[12] = pkt_buf[12] ^ 8'h80;
    send_packet();
  endtask

  task automatic test_id_mismatch();
    build_reply(4'd5, 16'd8, ~cfg_expected_id);
    send_packet();
  endtask

  task automatic test_malformed_lengths();
    // shorter than declared
    build_reply(4'd2, 16'd10, cfg_expected_id);
    repeat (3) void'(pkt_buf.pop_back());
    send_packet();
    // ends before the total length field is complete
    pkt_buf = '{8'h45};
    send_packet();
    pkt_buf = '{8'h45, 8'h00, 8'h00};
    send_packet();
    // total length below header length
    build_reply(4'd5, 16'd4, cfg_expected_id);
    pkt_buf[2] = 8'h00;
    pkt_buf[3] = 8'd12;
    send_packet();
    // zero header length
    build_reply(4'd5, 16'd8, cfg_expected_id);
    pkt_buf[0] = 8'h40;
    send_packet();
  endtask

  task automatic test_short_icmp();
    // empty ICMP part
    build_reply(4'd1, 16'd0, cfg_expected_id);
    send_packet();
    // identifier bytes missing in part or whole
    build_reply(4'd2, 16'd3, cfg_expected_id);
    send_packet();
    build_reply(4'd2, 16'd5, cfg_expected_id);
    send_packet();
    // bytes past the total length
    build_reply(4'd5, 16'd8, cfg_expected_id);
    repeat (3) pkt_buf.push_back(8'($urandom_range(0, 255)));
    send_packet();
  endtask

  // Good replies with random content half the time, the rest broken or noise.
  task automatic send_random_packet();
    int unsigned kind;
    int unsigned ihl;
    int unsigned len;
    int unsigned idx;
    logic [15:0] id;
    kind = $urandom_range(0, 9);
    ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : $urandom_range(1, 5);
    len  = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) begin
      id = 16'($urandom_range(0, 65535));
    end else begin
      id = cfg_expected_id;
    end
    build_reply(4'(ihl), 16'(len), id);
    case (kind)
      5: begin
        if (len > 0) begin
          idx = ihl * 4 + $urandom_range(0, len - 1);
          pkt_buf[idx] = pkt_buf[idx] ^ 8'($urandom_range(1, 255));
        end
      end
      6: begin
        repeat ($urandom_range(1, pkt_buf.size() - 1)) void'(pkt_buf.pop_back());
      end
      7: begin
        repeat ($urandom_range(1, 6)) pkt_buf.push_back(8'($urandom_range(0, 255)));
      end
      8: begin
        if ($urandom_range(0, 1) == 0) begin
          pkt_buf[0] = 8'($urandom_range(0, 15) << 4);
        end else begin
          pkt_buf[2] = 8'h00;
          pkt_buf[3] = 8'($urandom_range(0, ihl * 4 - 1));
        end
      end
      9: begin
        pkt_buf.delete();
        repeat ($urandom_range(1, 24)) pkt_buf.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    send_packet();
  endtask

  task automatic test_random_traffic(input int unsigned n_bytes, input int unsigned n_pkts);
    int unsigned bytes_end;
    int unsigned pkts_end;
    bytes_end = byte_count + n_bytes;
    pkts_end  = pkt_count + n_pkts;
    while (byte_count < bytes_end || pkt_count < pkts_end) begin
      idle_en = ($urandom_range(0, 4) != 0);
      send_random_packet();
    end
    wait_for_replies();
  endtask

  // Hold the result side off while packets keep coming.
  task automatic test_receiver_stall();
    idle_en       = 1'b0;
    long_hold_req = 1'b1;
    repeat (6) begin
      build_reply(4'd2, 16'd6, cfg_expected_id);
      send_packet();
    end
    wait_for_replies();
  endtask

  // Drive result ready: random stalls, one long hold on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    res_out.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        res_out.ready <= 1'b0;
      end else if (long_hold_req && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        hold_left       = LongHoldCycles - 1;
        res_out.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        hold_left = pick_gap() - 1;
        res_out.ready <= 1'b0;
      end else begin
        res_out.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest pending expectation.
  always @(posedge clk_i) begin : reply_check
    reply_check_t want;
    if (rst_ni === 1'b1 && res_out.valid === 1'b1 && res_out.ready === 1'b1) begin
      if (reply_q.size() == 0) begin
        error_count++;
        if (error_count <= MaxReported) begin
          $display("%0t: result with no packet pending: status %0d len %0d id %h",
                   $realtime, res_out.status, res_out.icmp_length, res_out.reply_id);
        end
      end else begin
        want = reply_q.pop_front();
        if (res_out.status !== want.status || res_out.icmp_length !== want.icmp_length ||
            res_out.reply_id !== want.reply_id) begin
          error_count++;
          if (error_count <= MaxReported) begin
            $display("%0t: mismatch: status %0d/%0d len %0d/%0d id %h/%h (expected/actual)",
                     $realtime, want.status, res_out.status, want.icmp_length,
                     res_out.icmp_length, want.reply_id, res_out.reply_id);
          end
        end
      end
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    pkt_in.valid     <= 1'b0;
    pkt_in.data_byte <= '0;
    pkt_in.last_byte <= 1'b0;
    cfg.valid        <= 1'b0;
    cfg.expected_id  <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_valid_replies();
    test_bad_checksum();
    test_id_mismatch();
    test_malformed_lengths();
    test_short_icmp();
    set_expected_id(16'hffff);
    test_random_traffic(150, 3);
    test_receiver_stall();
    set_expected_id(16'($urandom_range(1, 65534)));
    test_random_traffic(150, 3);

    error_count += reply_q.size();
    $display("Checked %0d packets over %0d bytes: %0d valid, %0d bad checksum,",
             pkt_count, byte_count, status_count[0], status_count[1]);
    $display("  %0d id mismatch, %0d malformed; identifier at reset value, all ones, random",
             status_count[2], status_count[3]);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop if the run hangs.
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/iecu_pkg.sv
rtl/core/iecu_byte_if.sv
rtl/core/iecu_result_if.sv
rtl/core/iecu_cfg_if.sv
rtl/core/iecu_front.sv
rtl/core/iecu_queue.sv
rtl/core/iecu_back.sv
rtl/core/icmp_echo_reply_checker_unit.sv
sim/icmp_echo_reply_checker_unit_tb.sv
